### src/fau_pkg.sv
// ----------------------------------------------------------------------------
// fau_pkg
// Shared types and constants for the fraction arithmetic unit.
// ----------------------------------------------------------------------------
package fau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_NUM_W         = 33;
    localparam int RES_DEN_W         = 31;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_GCD_DEN,
        CMD_GCD_RES,
        CMD_GCD_STEP,
        CMD_SAVE_G,
        CMD_DIV_QB,
        CMD_DIV_QA,
        CMD_DIV_MAG,
        CMD_DIV_DEN,
        CMD_DIV_STEP,
        CMD_SAVE_QB,
        CMD_SAVE_QA,
        CMD_SAVE_MAG,
        CMD_SAVE_DEN,
        CMD_MUL_LCM,
        CMD_MUL_TA,
        CMD_MUL_TB,
        CMD_COMBINE,
        CMD_MUL_NUM,
        CMD_MUL_DEN,
        CMD_FINISH
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD1_GO,
        ST_GCD1,
        ST_DIVQB_GO,
        ST_DIVQB,
        ST_DIVQA_GO,
        ST_DIVQA,
        ST_MUL_LCM,
        ST_MUL_TA,
        ST_MUL_TB,
        ST_COMBINE,
        ST_MUL_NUM,
        ST_MUL_DEN,
        ST_ZERO_CHK,
        ST_GCD2_GO,
        ST_GCD2,
        ST_DIVM_GO,
        ST_DIVM,
        ST_DIVD_GO,
        ST_DIVD,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic err_flag;
        logic addsub;
        logic mag_zero;
        logic gcd_done;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

### src/fau_in_if.sv
// ----------------------------------------------------------------------------
// fau_in_if
// Input channel: operation and two fractions.
// ----------------------------------------------------------------------------
interface fau_in_if #(
    parameter int OPERAND_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      mode;
    logic signed [OPERAND_WIDTH-1:0] num_a;
    logic [OPERAND_WIDTH-2:0]        den_a;
    logic signed [OPERAND_WIDTH-1:0] num_b;
    logic [OPERAND_WIDTH-2:0]        den_b;

    modport source (output valid, mode, num_a, den_a, num_b, den_b, input ready);
    modport sink   (input valid, mode, num_a, den_a, num_b, den_b, output ready);
endinterface

### src/fau_out_if.sv
// ----------------------------------------------------------------------------
// fau_out_if
// Output channel: reduced fraction and error code.
// ----------------------------------------------------------------------------
interface fau_out_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         error_code;

    modport source (output valid, res_num, res_den, error_code, input ready);
    modport sink   (input valid, res_num, res_den, error_code, output ready);
endinterface

### src/fraction_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
//  channel  dir  payload                              handshake
//  i_in     in   mode, num_a, den_a, num_b, den_b     valid/ready
//  o_out    out  res_num, res_den, error_code         valid/ready
//
//  One item at a time. Add/subtract: gcd of denominators, two quotients,
//  three multiplies and a combine, gcd of result, two quotients. Multiply/divide
//  skip the first gcd and quotients. Errors go straight to the finish state, and
//  a zero result skips the second gcd and quotients.
//  Synchronous active-low reset clears the sequencer and output valid.
//  A stalled result waits in the output register while the next item is taken.
module fraction_arithmetic_unit
    import fau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fau_in_if.sink         i_in,
    fau_out_if.source      o_out
);

    t_cmd    cmd;
    t_status status;

    fau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fau_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_mode       (i_in.mode),
        .i_num_a      (i_in.num_a),
        .i_den_a      (i_in.den_a),
        .i_num_b      (i_in.num_b),
        .i_den_b      (i_in.den_b),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_res_num    (o_out.res_num),
        .o_res_den    (o_out.res_den),
        .o_error_code (o_out.error_code)
    );

endmodule

### src/fau_ctrl.sv
// ----------------------------------------------------------------------------
// fau_ctrl
// Sequencer: steps the datapath through gcd, divide and multiply phases.
// ----------------------------------------------------------------------------
module fau_ctrl
    import fau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.err_flag)    n_state = ST_FINISH;
                else if (i_status.addsub) n_state = ST_GCD1_GO;
                else                      n_state = ST_MUL_NUM;
            end
            ST_GCD1_GO: begin
                o_cmd   = CMD_GCD_DEN;
                n_state = ST_GCD1;
            end
            ST_GCD1: begin
                if (i_status.gcd_done) begin
                    o_cmd   = CMD_SAVE_G;
                    n_state = ST_DIVQB_GO;
                end else begin
                    o_cmd = CMD_GCD_STEP;
                end
            end
            ST_DIVQB_GO: begin
                o_cmd   = CMD_DIV_QB;
                n_state = ST_DIVQB;
            end
            ST_DIVQB: begin
                if (i_status.div_done) begin
                    o_cmd   = CMD_SAVE_QB;
                    n_state = ST_DIVQA_GO;
                end else begin
                    o_cmd = CMD_DIV_STEP;
                end
            end
            ST_DIVQA_GO: begin
                o_cmd   = CMD_DIV_QA;
                n_state = ST_DIVQA;
            end
            ST_DIVQA: begin
                if (i_status.div_done) begin
                    o_cmd   = CMD_SAVE_QA;
                    n_state = ST_MUL_LCM;
                end else begin
                    o_cmd = CMD_DIV_STEP;
                end
            end
            ST_MUL_LCM: begin
                o_cmd   = CMD_MUL_LCM;
                n_state = ST_MUL_TA;
            end
            ST_MUL_TA: begin
                o_cmd   = CMD_MUL_TA;
                n_state = ST_MUL_TB;
            end
            ST_MUL_TB: begin
                o_cmd   = CMD_MUL_TB;
                n_state = ST_COMBINE;
            end
            ST_COMBINE: begin
                o_cmd   = CMD_COMBINE;
                n_state = ST_ZERO_CHK;
            end
            ST_MUL_NUM: begin
                o_cmd   = CMD_MUL_NUM;
                n_state = ST_MUL_DEN;
            end
            ST_MUL_DEN: begin
                o_cmd   = CMD_MUL_DEN;
                n_state = ST_ZERO_CHK;
            end
            ST_ZERO_CHK: begin
                n_state = i_status.mag_zero ? ST_FINISH : ST_GCD2_GO;
            end
            ST_GCD2_GO: begin
                o_cmd   = CMD_GCD_RES;
                n_state = ST_GCD2;
            end
            ST_GCD2: begin
                if (i_status.gcd_done) begin
                    o_cmd   = CMD_SAVE_G;
                    n_state = ST_DIVM_GO;
                end else begin
                    o_cmd = CMD_GCD_STEP;
                end
            end
            ST_DIVM_GO: begin
                o_cmd   = CMD_DIV_MAG;
                n_state = ST_DIVM;
            end
            ST_DIVM: begin
                if (i_status.div_done) begin
                    o_cmd   = CMD_SAVE_MAG;
                    n_state = ST_DIVD_GO;
                end else begin
                    o_cmd = CMD_DIV_STEP;
                end
            end
            ST_DIVD_GO: begin
                o_cmd   = CMD_DIV_DEN;
                n_state = ST_DIVD;
            end
            ST_DIVD: begin
                if (i_status.div_done) begin
                    o_cmd   = CMD_SAVE_DEN;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd = CMD_DIV_STEP;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd   = CMD_FINISH;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### src/fau_dp.sv
// ----------------------------------------------------------------------------
// fau_dp
// Datapath: operand registers, binary gcd, restoring divider, multiplier
// and output register.
// ----------------------------------------------------------------------------
module fau_dp
    import fau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cmd                            i_cmd,
    output t_status                         o_status,
    input  logic [1:0]                      i_mode,
    input  logic signed [OPERAND_WIDTH-1:0] i_num_a,
    input  logic [OPERAND_WIDTH-2:0]        i_den_a,
    input  logic signed [OPERAND_WIDTH-1:0] i_num_b,
    input  logic [OPERAND_WIDTH-2:0]        i_den_b,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [RES_NUM_W-1:0]     o_res_num,
    output logic [RES_DEN_W-1:0]            o_res_den,
    output logic [1:0]                      o_error_code
);

    localparam int W  = OPERAND_WIDTH;
    localparam int DW = W - 1;
    localparam int MW = 2 * W;
    localparam int NW = 2 * W + 1;
    localparam int KW = $clog2(MW + 1);

    logic [1:0]           r_mode;
    logic                 r_sa, r_sb;
    logic [W-1:0]         r_ma, r_mb;
    logic [DW-1:0]        r_da, r_db;
    logic [1:0]           r_err;
    logic [MW-1:0]        r_x, r_y, r_g;
    logic [KW-1:0]        r_k, r_cnt;
    logic [MW-1:0]        r_rem, r_quo, r_dvs;
    logic [DW-1:0]        r_qa, r_qb;
    logic signed [NW-1:0] r_ta, r_tb;
    logic [MW-1:0]        r_mag, r_den;
    logic                 r_neg;
    logic                 r_out_valid;
    logic [RES_NUM_W-1:0] r_res_num;
    logic [RES_DEN_W-1:0] r_res_den;
    logic [1:0]           r_res_err;

    logic [W-1:0]         abs_a, abs_b;
    logic [1:0]           load_err;
    logic [W-1:0]         mul_a, mul_b;
    logic [MW-1:0]        prod;
    logic signed [NW-1:0] sprod, sum;
    logic [MW-1:0]        gcd_val;
    logic [MW:0]          trial;
    logic                 fit;
    logic signed [NW-1:0] snum;

    assign abs_a = i_num_a[W-1] ? W'(-i_num_a) : W'(i_num_a);
    assign abs_b = i_num_b[W-1] ? W'(-i_num_b) : W'(i_num_b);

    always_comb begin
        if (i_den_a == '0 || i_den_b == '0)          load_err = ERR_ZERO_DEN;
        else if (i_mode == MODE_DIV && i_num_b == '0) load_err = ERR_DIV_ZERO;
        else                                         load_err = ERR_NONE;
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a = r_ma;
        mul_b = r_mb;
        case (i_cmd)
            CMD_MUL_LCM: begin
                mul_a = W'(r_da);
                mul_b = W'(r_qb);
            end
            CMD_MUL_TA: begin
                mul_a = r_ma;
                mul_b = W'(r_qb);
            end
            CMD_MUL_TB: begin
                mul_a = r_mb;
                mul_b = W'(r_qa);
            end
            CMD_MUL_NUM: begin
                mul_a = r_ma;
                mul_b = (r_mode == MODE_MUL) ? r_mb : W'(r_db);
            end
            CMD_MUL_DEN: begin
                mul_a = W'(r_da);
                mul_b = (r_mode == MODE_MUL) ? W'(r_db) : r_mb;
            end
            default: begin
                mul_a = r_ma;
                mul_b = r_mb;
            end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign sprod = signed'({1'b0, prod});
    assign sum   = (r_mode == MODE_ADD) ? r_ta + r_tb : r_ta - r_tb;

    assign gcd_val = (r_x | r_y) << r_k;
    assign trial   = {r_rem, r_quo[MW-1]};
    assign fit     = trial >= {1'b0, r_dvs};

    assign snum = r_neg ? -signed'({1'b0, r_mag}) : signed'({1'b0, r_mag});

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_mode <= i_mode;
                r_sa   <= i_num_a[W-1];
                r_sb   <= i_num_b[W-1];
                r_ma   <= abs_a;
                r_mb   <= abs_b;
                r_da   <= i_den_a;
                r_db   <= i_den_b;
                r_err  <= load_err;
            end
            CMD_GCD_DEN: begin
                r_x <= MW'(r_da);
                r_y <= MW'(r_db);
                r_k <= '0;
            end
            CMD_GCD_RES: begin
                r_x <= r_mag;
                r_y <= r_den;
                r_k <= '0;
            end
            CMD_GCD_STEP: begin
                if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= (r_x - r_y) >> 1;
                end else begin
                    r_y <= (r_y - r_x) >> 1;
                end
            end
            CMD_SAVE_G: r_g <= gcd_val;
            CMD_DIV_QB, CMD_DIV_QA, CMD_DIV_MAG, CMD_DIV_DEN: begin
                r_rem <= '0;
                r_dvs <= r_g;
                r_cnt <= KW'(MW);
                case (i_cmd)
                    CMD_DIV_QB:  r_quo <= MW'(r_db);
                    CMD_DIV_QA:  r_quo <= MW'(r_da);
                    CMD_DIV_MAG: r_quo <= r_mag;
                    default:     r_quo <= r_den;
                endcase
            end
            CMD_DIV_STEP: begin
                r_rem <= fit ? MW'(trial - {1'b0, r_dvs}) : trial[MW-1:0];
                r_quo <= {r_quo[MW-2:0], fit};
                r_cnt <= r_cnt - 1'b1;
            end
            CMD_SAVE_QB:  r_qb  <= r_quo[DW-1:0];
            CMD_SAVE_QA:  r_qa  <= r_quo[DW-1:0];
            CMD_SAVE_MAG: r_mag <= r_quo;
            CMD_SAVE_DEN: r_den <= r_quo;
            CMD_MUL_LCM:  r_den <= prod;
            CMD_MUL_TA:   r_ta  <= r_sa ? -sprod : sprod;
            CMD_MUL_TB:   r_tb  <= r_sb ? -sprod : sprod;
            CMD_COMBINE: begin
                r_neg <= sum[NW-1];
                r_mag <= sum[NW-1] ? MW'(-sum) : MW'(sum);
            end
            CMD_MUL_NUM: begin
                r_mag <= prod;
                r_neg <= r_sa ^ r_sb;
            end
            CMD_MUL_DEN: r_den <= prod;
            CMD_FINISH: begin
                if (r_err != ERR_NONE) begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                end else if (r_mag == '0) begin
                    r_res_num <= '0;
                    r_res_den <= RES_DEN_W'(1);
                end else begin
                    r_res_num <= RES_NUM_W'(snum);
                    r_res_den <= RES_DEN_W'(r_den);
                end
                r_res_err <= r_err;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == CMD_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.err_flag = (r_err != ERR_NONE);
    assign o_status.addsub   = (r_mode == MODE_ADD) || (r_mode == MODE_SUB);
    assign o_status.mag_zero = (r_mag == '0);
    assign o_status.gcd_done = (r_x == '0) || (r_y == '0);
    assign o_status.div_done = (r_cnt == '0);
    assign o_status.out_free = !r_out_valid || i_ready;

    assign o_valid      = r_out_valid;
    assign o_res_num    = signed'(r_res_num);
    assign o_res_den    = r_res_den;
    assign o_error_code = r_res_err;

endmodule
